// ===== src/ipac_pkg.sv =====
// ipv6 address classifier package: result codes, counter layout, service port table
// and the small helper functions used by the decode logic
// no dependencies
package ipac_pkg;

    localparam int CNT_WIDTH_DEF = 32;
    localparam int CNT_NUM       = 36;
    localparam int CNT_IDX_W     = 6;
    localparam int CNT_OUT_W     = 32;

    // command codes
    localparam logic CMD_CLASSIFY = 1'b0;
    localparam logic CMD_READ     = 1'b1;

    // address type
    localparam logic [1:0] ATYPE_UNSPEC  = 2'd0;
    localparam logic [1:0] ATYPE_UNICAST = 2'd1;
    localparam logic [1:0] ATYPE_MCAST   = 2'd2;

    // subtype
    localparam logic [3:0] SUB_UNSPEC     = 4'd0;
    localparam logic [3:0] SUB_LOOPBACK   = 4'd1;
    localparam logic [3:0] SUB_V4MAPPED   = 4'd2;
    localparam logic [3:0] SUB_V4COMPAT   = 4'd3;
    localparam logic [3:0] SUB_LINKLOCAL  = 4'd4;
    localparam logic [3:0] SUB_SITELOCAL  = 4'd5;
    localparam logic [3:0] SUB_UNIQLOCAL  = 4'd6;
    localparam logic [3:0] SUB_6TO4       = 4'd7;
    localparam logic [3:0] SUB_TEREDO     = 4'd8;
    localparam logic [3:0] SUB_GLOBAL     = 4'd9;
    localparam logic [3:0] SUB_MC_PERM    = 4'd10;
    localparam logic [3:0] SUB_MC_NONPERM = 4'd11;
    localparam logic [3:0] SUB_MC_INVALID = 4'd12;
    localparam logic [3:0] SUB_MC_UCBASED = 4'd13;
    localparam logic [3:0] SUB_MC_EMBRP   = 4'd14;
    localparam logic [3:0] SUB_MC_UNKNOWN = 4'd15;

    // scope
    localparam logic [3:0] SCOPE_RSV      = 4'd0;
    localparam logic [3:0] SCOPE_IFACE    = 4'd1;
    localparam logic [3:0] SCOPE_LL       = 4'd2;
    localparam logic [3:0] SCOPE_AL       = 4'd3;
    localparam logic [3:0] SCOPE_SL       = 4'd4;
    localparam logic [3:0] SCOPE_ORG      = 4'd5;
    localparam logic [3:0] SCOPE_WORLD    = 4'd6;
    localparam logic [3:0] SCOPE_UNASSIGN = 4'd7;
    localparam logic [3:0] SCOPE_UNSPEC   = 4'd8;

    // interface id class
    localparam logic [3:0] IID_NONE       = 4'd0;
    localparam logic [3:0] IID_MAC        = 4'd1;
    localparam logic [3:0] IID_TUNNEL     = 4'd2;
    localparam logic [3:0] IID_EMB_V4     = 4'd3;
    localparam logic [3:0] IID_PORT       = 4'd4;
    localparam logic [3:0] IID_PORT_REV   = 4'd5;
    localparam logic [3:0] IID_LOW_BYTE   = 4'd6;
    localparam logic [3:0] IID_EMB_V4_64  = 4'd7;
    localparam logic [3:0] IID_PATTERN    = 4'd8;
    localparam logic [3:0] IID_OPAQUE     = 4'd9;

    // counter layout
    localparam logic [CNT_IDX_W-1:0] CIX_TOTAL     = 6'd0;
    localparam logic [CNT_IDX_W-1:0] CIX_UNICAST   = 6'd1;
    localparam logic [CNT_IDX_W-1:0] CIX_MCAST     = 6'd2;
    localparam logic [CNT_IDX_W-1:0] CIX_UNSPEC    = 6'd3;
    localparam logic [CNT_IDX_W-1:0] CIX_SUB_OFS   = 6'd3;
    localparam logic [CNT_IDX_W-1:0] CIX_SCOPE_OFS = 6'd19;
    localparam logic [CNT_IDX_W-1:0] CIX_MAC       = 6'd27;
    localparam logic [CNT_IDX_W-1:0] CIX_ISATAP    = 6'd28;
    localparam logic [CNT_IDX_W-1:0] CIX_EMB_V4    = 6'd29;
    localparam logic [CNT_IDX_W-1:0] CIX_EMB_V4_64 = 6'd30;
    localparam logic [CNT_IDX_W-1:0] CIX_PORT      = 6'd31;
    localparam logic [CNT_IDX_W-1:0] CIX_PORT_REV  = 6'd32;
    localparam logic [CNT_IDX_W-1:0] CIX_LOW_BYTE  = 6'd33;
    localparam logic [CNT_IDX_W-1:0] CIX_PATTERN   = 6'd34;
    localparam logic [CNT_IDX_W-1:0] CIX_RANDOM    = 6'd35;

    // counters are kept in small banks, one per statistics group
    localparam int NUM_GRP = 5;
    localparam int GRP_BASE [NUM_GRP] = '{0, 4, 13, 19, 27};
    localparam int GRP_SIZE [NUM_GRP] = '{4, 9, 6, 8, 9};

    localparam int NUM_SVC = 46;
    localparam logic [15:0] SVC_PORTS [NUM_SVC] = '{
        16'h0021, 16'h0022, 16'h0023, 16'h0025, 16'h0049, 16'h0053, 16'h0080,
        16'h0110, 16'h0123, 16'h0179, 16'h0220, 16'h0389, 16'h0443, 16'h0547,
        16'h0993, 16'h0995, 16'h1194, 16'h3306, 16'h5060, 16'h5061, 16'h5432,
        16'h6446, 16'h8080,
        16'd21, 16'd22, 16'd23, 16'd25, 16'd49, 16'd53, 16'd80, 16'd110,
        16'd123, 16'd179, 16'd220, 16'd389, 16'd443, 16'd547, 16'd993,
        16'd995, 16'd1194, 16'd3306, 16'd5060, 16'd5061, 16'd5432, 16'd6446,
        16'd8080
    };

    typedef struct packed {
        logic [1:0]  addr_type;
        logic [3:0]  addr_subtype;
        logic [3:0]  addr_scope;
        logic [3:0]  iid_type;
        logic [23:0] oui;
    } t_class_res;

    function automatic logic in_port_list(input logic [15:0] p);
        logic hit;
        hit = 1'b0;
        for (int i = 0; i < NUM_SVC; i++) begin
            hit = hit | (p == SVC_PORTS[i]);
        end
        return hit;
    endfunction

    function automatic logic [CNT_IDX_W-1:0] iid_cnt_idx(input logic [3:0] iid);
        logic [CNT_IDX_W-1:0] idx;
        case (iid)
            IID_MAC:       idx = CIX_MAC;
            IID_TUNNEL:    idx = CIX_ISATAP;
            IID_EMB_V4:    idx = CIX_EMB_V4;
            IID_PORT:      idx = CIX_PORT;
            IID_PORT_REV:  idx = CIX_PORT_REV;
            IID_LOW_BYTE:  idx = CIX_LOW_BYTE;
            IID_EMB_V4_64: idx = CIX_EMB_V4_64;
            IID_PATTERN:   idx = CIX_PATTERN;
            default:       idx = CIX_RANDOM;
        endcase
        return idx;
    endfunction

endpackage

// ===== src/ipac_classify.sv =====
// address and interface id decode, plus the set of counters each item bumps
// depends on ipac_pkg
module ipac_classify import ipac_pkg::*; (
    input  logic [63:0]        i_addr_high,
    input  logic [63:0]        i_addr_low,
    output t_class_res         o_res,
    output logic [CNT_NUM-1:0] o_bump
);

    logic [31:0] w2, w3;
    logic [15:0] s4, s5, s6, s7;
    logic [3:0]  zero_cnt;
    logic [3:0]  iid;
    logic [23:0] iid_oui;
    logic [1:0]  a_type;
    logic [3:0]  a_sub;
    logic [3:0]  a_scope;
    logic        eligible;
    logic [CNT_IDX_W-1:0] type_idx, sub_idx, scope_idx, iid_idx;

    assign w2 = i_addr_low[63:32];
    assign w3 = i_addr_low[31:0];
    assign s4 = i_addr_low[63:48];
    assign s5 = i_addr_low[47:32];
    assign s6 = i_addr_low[31:16];
    assign s7 = i_addr_low[15:0];

    always_comb begin
        zero_cnt = '0;
        for (int i = 0; i < 8; i++) begin
            zero_cnt = zero_cnt + 4'(i_addr_low[8*i +: 8] == 8'h00);
        end
    end

    // interface id class, first match wins
    always_comb begin
        iid_oui = '0;
        if ((w2 & 32'h020000ff) == 32'h020000ff && w3[31:24] == 8'hfe) begin
            iid     = IID_MAC;
            iid_oui = w2[31:8] & 24'hfdffff;
        end else if ((w2 & 32'hfdffffff) == 32'h00005efe) begin
            iid = IID_TUNNEL;
        end else if (w2 == '0 && s6[15:8] != '0 && s7 != '0) begin
            iid = IID_EMB_V4;
        end else if (w2 == '0 && s6[15:8] == '0 && in_port_list(s7)) begin
            iid = IID_PORT;
        end else if (w2 == '0 && s7[15:8] == '0 && in_port_list(s6)) begin
            iid = IID_PORT_REV;
        end else if (w2 == '0 && s6[15:8] == '0 && s7 != '0) begin
            iid = IID_LOW_BYTE;
        end else if (s4 <= 16'h0255 && s5 <= 16'h0255 && s6 <= 16'h0255
                     && s7 <= 16'h0255) begin
            iid = IID_EMB_V4_64;
        end else if (zero_cnt > 4'd2) begin
            iid = IID_PATTERN;
        end else begin
            iid = IID_OPAQUE;
        end
    end

    // address type, subtype and scope
    always_comb begin
        a_type  = ATYPE_UNICAST;
        a_sub   = SUB_GLOBAL;
        a_scope = SCOPE_WORLD;
        if (i_addr_high == '0 && i_addr_low == '0) begin
            a_type  = ATYPE_UNSPEC;
            a_sub   = SUB_UNSPEC;
            a_scope = SCOPE_UNSPEC;
        end else if (i_addr_high[63:56] == 8'hff) begin
            a_type = ATYPE_MCAST;
            case (i_addr_high[55:52])
                4'd0:                      a_sub = SUB_MC_PERM;
                4'd1:                      a_sub = SUB_MC_NONPERM;
                4'd3:                      a_sub = SUB_MC_UCBASED;
                4'd7:                      a_sub = SUB_MC_EMBRP;
                4'd2, 4'd4, 4'd5, 4'd6:    a_sub = SUB_MC_INVALID;
                default:                   a_sub = SUB_MC_UNKNOWN;
            endcase
            case (i_addr_high[51:48])
                4'h0, 4'h3: a_scope = SCOPE_RSV;
                4'h1:       a_scope = SCOPE_IFACE;
                4'h2:       a_scope = SCOPE_LL;
                4'h4:       a_scope = SCOPE_AL;
                4'h5:       a_scope = SCOPE_SL;
                4'h8:       a_scope = SCOPE_ORG;
                4'he:       a_scope = SCOPE_WORLD;
                default:    a_scope = SCOPE_UNASSIGN;
            endcase
        end else if (i_addr_high == '0 && i_addr_low == 64'd1) begin
            a_sub   = SUB_LOOPBACK;
            a_scope = SCOPE_IFACE;
        end else if (i_addr_high == '0 && i_addr_low[63:32] == 32'h0000ffff) begin
            a_sub   = SUB_V4MAPPED;
            a_scope = SCOPE_UNSPEC;
        end else if (i_addr_high == '0 && i_addr_low[63:32] == '0) begin
            a_sub   = SUB_V4COMPAT;
            a_scope = SCOPE_UNSPEC;
        end else if (i_addr_high[63:54] == 10'h3fa) begin
            a_sub   = SUB_LINKLOCAL;
            a_scope = SCOPE_LL;
        end else if (i_addr_high[63:54] == 10'h3fb) begin
            a_sub   = SUB_SITELOCAL;
            a_scope = SCOPE_SL;
        end else if (i_addr_high[63:57] == 7'h7e) begin
            a_sub = SUB_UNIQLOCAL;
        end else if (i_addr_high[63:48] == 16'h2002) begin
            a_sub = SUB_6TO4;
        end else if (i_addr_high[63:32] == 32'h20010000
                     || i_addr_high[63:32] == 32'h3ffe831f) begin
            a_sub = SUB_TEREDO;
        end
    end

    assign eligible = (a_type == ATYPE_UNICAST) && (a_sub != SUB_LOOPBACK)
                      && (a_sub != SUB_TEREDO);

    always_comb begin
        o_res.addr_type    = a_type;
        o_res.addr_subtype = a_sub;
        o_res.addr_scope   = a_scope;
        o_res.iid_type     = eligible ? iid : IID_NONE;
        o_res.oui          = eligible ? iid_oui : '0;
    end

    always_comb begin
        case (a_type)
            ATYPE_UNICAST: type_idx = CIX_UNICAST;
            ATYPE_MCAST:   type_idx = CIX_MCAST;
            default:       type_idx = CIX_UNSPEC;
        endcase
    end

    assign sub_idx   = CIX_SUB_OFS + CNT_IDX_W'(a_sub);
    assign scope_idx = CIX_SCOPE_OFS + CNT_IDX_W'(a_scope);
    assign iid_idx   = iid_cnt_idx(iid);

    always_comb begin
        for (int i = 0; i < CNT_NUM; i++) begin
            o_bump[i] = (CNT_IDX_W'(i) == CIX_TOTAL)
                     || (CNT_IDX_W'(i) == type_idx)
                     || (a_type != ATYPE_UNSPEC && CNT_IDX_W'(i) == sub_idx)
                     || (a_type == ATYPE_MCAST && CNT_IDX_W'(i) == scope_idx)
                     || (eligible && CNT_IDX_W'(i) == iid_idx);
        end
    end

endmodule

// ===== src/ipac_cnt_bank.sv =====
// bank of saturating event counters with a one-hot read select
// follows the house conventions but imports nothing from ipac_pkg; standalone logic
module ipac_cnt_bank #(
    parameter int N     = 4,
    parameter int CNT_W = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_inc_en,
    input  logic [N-1:0]     i_bump,
    input  logic [N-1:0]     i_rd_sel,
    output logic [CNT_W-1:0] o_rd_data
);

    logic [CNT_W-1:0] r_cnt [N];

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < N; i++) begin
            if (!i_rst_n) begin
                r_cnt[i] <= '0;
            end else if (i_inc_en && i_bump[i] && !(&r_cnt[i])) begin
                r_cnt[i] <= r_cnt[i] + CNT_W'(1);
            end
        end
    end

    always_comb begin
        o_rd_data = '0;
        for (int i = 0; i < N; i++) begin
            o_rd_data = o_rd_data | (i_rd_sel[i] ? r_cnt[i] : '0);
        end
    end

endmodule

// ===== src/ipv6_address_classifier.sv =====
// top level: input register, address decode, counter banks and result register
// depends on ipac_pkg, ipac_classify and ipac_cnt_bank
//
// One item per clock cycle while the input is not stalled; each item passes
// the input register and then the result register (one input register, one
// result register). A classify command (cmd 0) returns type, subtype, scope,
// interface id class and OUI and bumps the matching saturating counters as the
// item leaves the input register; a read command (cmd 1) returns the counter
// at counter_index, which already includes every classify item accepted before
// it. Indexes above 35 read as zero. Counters are COUNTER_WIDTH bits and reset
// to zero; counter_value shows their low 32 bits. The input stalls only while a
// result is held back by output stall and the input register is full.
module ipv6_address_classifier import ipac_pkg::*; #(
    parameter int COUNTER_WIDTH = CNT_WIDTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic                 i_cmd,
    input  logic [63:0]          i_addr_high,
    input  logic [63:0]          i_addr_low,
    input  logic [CNT_IDX_W-1:0] i_counter_index,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [1:0]           o_addr_type,
    output logic [3:0]           o_addr_subtype,
    output logic [3:0]           o_addr_scope,
    output logic [3:0]           o_iid_type,
    output logic [23:0]          o_oui,
    output logic [CNT_OUT_W-1:0] o_counter_value
);

    logic                 r_s1_valid;
    logic                 r_s1_cmd;
    logic [63:0]          r_s1_hi;
    logic [63:0]          r_s1_lo;
    logic [CNT_IDX_W-1:0] r_s1_idx;

    logic                 r_out_valid;
    t_class_res           r_out_res;
    logic [CNT_OUT_W-1:0] r_out_cnt;

    logic                 out_hold;
    logic                 s1_move;
    logic                 s1_load;
    t_class_res           cls_res;
    logic [CNT_NUM-1:0]   bump;
    logic [CNT_NUM-1:0]   rd_sel;
    logic [COUNTER_WIDTH-1:0] grp_rd [NUM_GRP];
    logic [COUNTER_WIDTH-1:0] cnt_rd;
    logic [63:0]          cnt_rd_ext;
    logic                 inc_en;

    assign out_hold   = r_out_valid && i_out_stall;
    assign s1_move    = r_s1_valid && !out_hold;
    assign o_in_stall = r_s1_valid && out_hold;
    assign s1_load    = i_in_valid && !o_in_stall;
    assign inc_en     = s1_move && (r_s1_cmd == CMD_CLASSIFY);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s1_load) begin
            r_s1_valid <= 1'b1;
        end else if (s1_move) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_load) begin
            r_s1_cmd <= i_cmd;
            r_s1_hi  <= i_addr_high;
            r_s1_lo  <= i_addr_low;
            r_s1_idx <= i_counter_index;
        end
    end

    ipac_classify u_classify (
        .i_addr_high (r_s1_hi),
        .i_addr_low  (r_s1_lo),
        .o_res       (cls_res),
        .o_bump      (bump)
    );

    always_comb begin
        for (int i = 0; i < CNT_NUM; i++) begin
            rd_sel[i] = (r_s1_cmd == CMD_READ) && (r_s1_idx == CNT_IDX_W'(i));
        end
    end

    for (genvar g = 0; g < NUM_GRP; g++) begin : g_bank
        ipac_cnt_bank #(
            .N     (GRP_SIZE[g]),
            .CNT_W (COUNTER_WIDTH)
        ) u_bank (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_inc_en  (inc_en),
            .i_bump    (bump[GRP_BASE[g] +: GRP_SIZE[g]]),
            .i_rd_sel  (rd_sel[GRP_BASE[g] +: GRP_SIZE[g]]),
            .o_rd_data (grp_rd[g])
        );
    end

    always_comb begin
        cnt_rd = '0;
        for (int g = 0; g < NUM_GRP; g++) begin
            cnt_rd = cnt_rd | grp_rd[g];
        end
    end

    assign cnt_rd_ext = 64'(cnt_rd);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_move) begin
            r_out_valid <= 1'b1;
        end else if (!out_hold) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_move) begin
            if (r_s1_cmd == CMD_READ) begin
                r_out_res <= '0;
                r_out_cnt <= cnt_rd_ext[CNT_OUT_W-1:0];
            end else begin
                r_out_res <= cls_res;
                r_out_cnt <= '0;
            end
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_addr_type     = r_out_res.addr_type;
    assign o_addr_subtype  = r_out_res.addr_subtype;
    assign o_addr_scope    = r_out_res.addr_scope;
    assign o_iid_type      = r_out_res.iid_type;
    assign o_oui           = r_out_res.oui;
    assign o_counter_value = r_out_cnt;

endmodule

// ===== verif/tb_top.sv =====
// testbench for ipv6_address_classifier: address classes, interface id classes
// and event counter reads checked against an in-bench predictor
// depends on ipac_pkg and ipv6_address_classifier
module tb_top;
    import ipac_pkg::*;

    localparam int CNT_W          = CNT_WIDTH_DEF;
    localparam int NUM_ITEMS      = 1250;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 10;

    localparam logic [15:0] SERVICE_PORTS [46] = '{
        16'h0021, 16'h0022, 16'h0023, 16'h0025, 16'h0049, 16'h0053, 16'h0080,
        16'h0110, 16'h0123, 16'h0179, 16'h0220, 16'h0389, 16'h0443, 16'h0547,
        16'h0993, 16'h0995, 16'h1194, 16'h3306, 16'h5060, 16'h5061, 16'h5432,
        16'h6446, 16'h8080,
        16'd21, 16'd22, 16'd23, 16'd25, 16'd49, 16'd53, 16'd80, 16'd110,
        16'd123, 16'd179, 16'd220, 16'd389, 16'd443, 16'd547, 16'd993,
        16'd995, 16'd1194, 16'd3306, 16'd5060, 16'd5061, 16'd5432, 16'd6446,
        16'd8080
    };

    typedef struct packed {
        logic [1:0]  addr_type;
        logic [3:0]  addr_subtype;
        logic [3:0]  addr_scope;
        logic [3:0]  iid_type;
        logic [23:0] oui;
        logic [31:0] counter_value;
    } t_class_result;

    class t_classifier_scoreboard;
        logic [CNT_W-1:0] event_count [CNT_NUM];
        t_class_result    expected_classes [$];
        int unsigned      errors;

        function new();
            for (int i = 0; i < CNT_NUM; i++) begin
                event_count[i] = '0;
            end
            errors = 0;
        endfunction

        function void bump(int idx);
            if (event_count[idx] != {CNT_W{1'b1}}) begin
                event_count[idx] = event_count[idx] + 1'b1;
            end
        endfunction

        function bit port_listed(logic [15:0] p);
            foreach (SERVICE_PORTS[i]) begin
                if (p == SERVICE_PORTS[i]) begin
                    return 1'b1;
                end
            end
            return 1'b0;
        endfunction

        function logic [3:0] classify_iid_bits(logic [63:0] lo, output logic [23:0] oui);
            logic [31:0] w2;
            logic [15:0] s4, s5, s6, s7;
            int          zeros;
            w2 = lo[63:32];
            s4 = lo[63:48];
            s5 = lo[47:32];
            s6 = lo[31:16];
            s7 = lo[15:0];
            oui = '0;
            zeros = 0;
            for (int b = 0; b < 8; b++) begin
                if (lo[8*b +: 8] == 8'h00) begin
                    zeros++;
                end
            end
            if ((w2 & 32'h020000ff) == 32'h020000ff && lo[31:24] == 8'hfe) begin
                oui = w2[31:8] & 24'hfdffff;
                return IID_MAC;
            end
            if ((w2 & 32'hfdffffff) == 32'h00005efe) begin
                return IID_TUNNEL;
            end
            if (w2 == '0 && s6[15:8] != '0 && s7 != '0) begin
                return IID_EMB_V4;
            end
            if (w2 == '0 && s6[15:8] == '0 && port_listed(s7)) begin
                return IID_PORT;
            end
            if (w2 == '0 && s7[15:8] == '0 && port_listed(s6)) begin
                return IID_PORT_REV;
            end
            if (w2 == '0 && s6[15:8] == '0 && s7 != '0) begin
                return IID_LOW_BYTE;
            end
            if (s4 <= 16'h0255 && s5 <= 16'h0255 && s6 <= 16'h0255 && s7 <= 16'h0255) begin
                return IID_EMB_V4_64;
            end
            if (zeros > 2) begin
                return IID_PATTERN;
            end
            return IID_OPAQUE;
        endfunction

        function int iid_counter(logic [3:0] iid);
            case (iid)
                IID_MAC:       return CIX_MAC;
                IID_TUNNEL:    return CIX_ISATAP;
                IID_EMB_V4:    return CIX_EMB_V4;
                IID_EMB_V4_64: return CIX_EMB_V4_64;
                IID_PORT:      return CIX_PORT;
                IID_PORT_REV:  return CIX_PORT_REV;
                IID_LOW_BYTE:  return CIX_LOW_BYTE;
                IID_PATTERN:   return CIX_PATTERN;
                default:       return CIX_RANDOM;
            endcase
        endfunction

        function t_class_result predict_class(logic cmd, logic [63:0] hi, logic [63:0] lo,
                                              logic [5:0] idx);
            t_class_result r;
            logic [3:0]    flags;
            logic [3:0]    nib;
            logic [23:0]   oui;
            r = '0;
            if (cmd == CMD_READ) begin
                if (idx < CNT_NUM) begin
                    r.counter_value = event_count[idx];
                end
                return r;
            end
            r.addr_scope = SCOPE_UNSPEC;
            bump(CIX_TOTAL);
            if (hi == '0 && lo == '0) begin
                bump(CIX_UNSPEC);
            end else if (hi[63:56] == 8'hff) begin
                flags = hi[55:52];
                nib = hi[51:48];
                r.addr_type = ATYPE_MCAST;
                bump(CIX_MCAST);
                case (flags)
                    4'd0:                r.addr_subtype = SUB_MC_PERM;
                    4'd1:                r.addr_subtype = SUB_MC_NONPERM;
                    4'd3:                r.addr_subtype = SUB_MC_UCBASED;
                    4'd7:                r.addr_subtype = SUB_MC_EMBRP;
                    4'd2, 4'd4, 4'd5, 4'd6: r.addr_subtype = SUB_MC_INVALID;
                    default:             r.addr_subtype = SUB_MC_UNKNOWN;
                endcase
                bump(int'(r.addr_subtype) + int'(CIX_SUB_OFS));
                case (nib)
                    4'h0, 4'h3: r.addr_scope = SCOPE_RSV;
                    4'h1:       r.addr_scope = SCOPE_IFACE;
                    4'h2:       r.addr_scope = SCOPE_LL;
                    4'h4:       r.addr_scope = SCOPE_AL;
                    4'h5:       r.addr_scope = SCOPE_SL;
                    4'h8:       r.addr_scope = SCOPE_ORG;
                    4'he:       r.addr_scope = SCOPE_WORLD;
                    default:    r.addr_scope = SCOPE_UNASSIGN;
                endcase
                bump(int'(r.addr_scope) + int'(CIX_SCOPE_OFS));
            end else begin
                r.addr_type = ATYPE_UNICAST;
                bump(CIX_UNICAST);
                if (hi == '0 && lo == 64'd1) begin
                    r.addr_subtype = SUB_LOOPBACK;
                    r.addr_scope = SCOPE_IFACE;
                end else if (hi == '0 && lo[63:32] == 32'h0000ffff) begin
                    r.addr_subtype = SUB_V4MAPPED;
                end else if (hi == '0 && lo[63:32] == '0) begin
                    r.addr_subtype = SUB_V4COMPAT;
                end else if (hi[63:54] == 10'h3fa) begin
                    r.addr_subtype = SUB_LINKLOCAL;
                    r.addr_scope = SCOPE_LL;
                end else if (hi[63:54] == 10'h3fb) begin
                    r.addr_subtype = SUB_SITELOCAL;
                    r.addr_scope = SCOPE_SL;
                end else if (hi[63:57] == 7'h7e) begin
                    r.addr_subtype = SUB_UNIQLOCAL;
                    r.addr_scope = SCOPE_WORLD;
                end else if (hi[63:48] == 16'h2002) begin
                    r.addr_subtype = SUB_6TO4;
                    r.addr_scope = SCOPE_WORLD;
                end else if (hi[63:32] == 32'h20010000 || hi[63:32] == 32'h3ffe831f) begin
                    r.addr_subtype = SUB_TEREDO;
                    r.addr_scope = SCOPE_WORLD;
                end else begin
                    r.addr_subtype = SUB_GLOBAL;
                    r.addr_scope = SCOPE_WORLD;
                end
                bump(int'(r.addr_subtype) + int'(CIX_SUB_OFS));
                // loopback and teredo carry no interface id class
                if (r.addr_subtype != SUB_LOOPBACK && r.addr_subtype != SUB_TEREDO) begin
                    r.iid_type = classify_iid_bits(lo, oui);
                    r.oui = oui;
                    bump(iid_counter(r.iid_type));
                end
            end
            return r;
        endfunction

        function void note_address_item(logic cmd, logic [63:0] hi, logic [63:0] lo,
                                        logic [5:0] idx);
            expected_classes.push_back(predict_class(cmd, hi, lo, idx));
        endfunction

        function void cmp_field(string field_name, logic [31:0] want, logic [31:0] got);
            if (got !== want) begin
                $error("%s mismatch: expected 0x%0h, got 0x%0h", field_name, want, got);
                errors++;
            end
        endfunction

        function void check_class_result(t_class_result got);
            t_class_result want;
            if (expected_classes.size() == 0) begin
                $error("result with no item pending");
                errors++;
                return;
            end
            want = expected_classes.pop_front();
            cmp_field("addr_type", 32'(want.addr_type), 32'(got.addr_type));
            cmp_field("addr_subtype", 32'(want.addr_subtype), 32'(got.addr_subtype));
            cmp_field("addr_scope", 32'(want.addr_scope), 32'(got.addr_scope));
            cmp_field("iid_type", 32'(want.iid_type), 32'(got.iid_type));
            cmp_field("oui", 32'(want.oui), 32'(got.oui));
            cmp_field("counter_value", want.counter_value, got.counter_value);
        endfunction

        function int pending();
            return expected_classes.size();
        endfunction
    endclass

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_stall;
    logic                 i_cmd;
    logic [63:0]          i_addr_high;
    logic [63:0]          i_addr_low;
    logic [CNT_IDX_W-1:0] i_counter_index;
    logic                 o_out_valid;
    logic                 i_out_stall;
    logic [1:0]           o_addr_type;
    logic [3:0]           o_addr_subtype;
    logic [3:0]           o_addr_scope;
    logic [3:0]           o_iid_type;
    logic [23:0]          o_oui;
    logic [CNT_OUT_W-1:0] o_counter_value;

    t_classifier_scoreboard sb;
    bit                     in_burst;
    bit                     out_burst;
    int unsigned            idle_cycles;

    ipv6_address_classifier DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_cmd           (i_cmd),
        .i_addr_high     (i_addr_high),
        .i_addr_low      (i_addr_low),
        .i_counter_index (i_counter_index),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_addr_type     (o_addr_type),
        .o_addr_subtype  (o_addr_subtype),
        .o_addr_scope    (o_addr_scope),
        .o_iid_type      (o_iid_type),
        .o_oui           (o_oui),
        .o_counter_value (o_counter_value)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // mostly well-formed interface ids of each class, some near misses
    function automatic logic [63:0] rand_iid();
        logic [63:0] v;
        logic [31:0] r;
        logic [15:0] p;
        v = rand64();
        r = $urandom;
        p = SERVICE_PORTS[$urandom_range(0, 45)];
        if ($urandom_range(0, 1) == 0) begin
            r[7:0] = 8'h00;
        end
        case ($urandom_range(0, 9))
            0: begin
                v[39:32] = 8'hff;
                v[31:24] = 8'hfe;
                if ($urandom_range(0, 3) != 0) begin
                    v[57] = 1'b1;
                end
            end
            1: begin
                v[63:32] = 32'h00005efe;
                v[57] = r[31];
            end
            2: v = {32'h0, r};
            3: v = {32'h0, 8'h00, r[7:0], p};
            4: v = {32'h0, p, 8'h00, r[7:0]};
            5: v = {32'h0, 8'h00, r[7:0], r[31:16]};
            6: begin
                for (int g = 0; g < 4; g++) begin
                    v[16*g +: 16] = 16'($urandom_range(0, 16'h0260));
                end
            end
            7: begin
                for (int b = 0; b < 8; b++) begin
                    if ($urandom_range(0, 1) == 0) begin
                        v[8*b +: 8] = 8'h00;
                    end
                end
            end
            default: ;
        endcase
        return v;
    endfunction

    function automatic logic [63:0] rand_prefix();
        logic [63:0] v;
        v = rand64();
        case ($urandom_range(0, 11))
            0:       v = '0;
            1, 2:    v[63:56] = 8'hff;
            3:       v[63:54] = 10'h3fa;
            4:       v[63:54] = 10'h3fb;
            5:       v[63:57] = 7'h7e;
            6:       v[63:48] = 16'h2002;
            7:       v[63:32] = $urandom_range(0, 1) ? 32'h20010000 : 32'h3ffe831f;
            8:       v[63:48] = 16'h2001;
            default: ;
        endcase
        return v;
    endfunction

    task automatic drive_item(input logic cmd, input logic [63:0] hi, input logic [63:0] lo,
                              input logic [5:0] idx);
        int unsigned gap;
        gap = in_burst ? 0 : $urandom_range(0, 10);
        if (gap != 0) begin
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_cmd = cmd;
        i_addr_high = hi;
        i_addr_low = lo;
        i_counter_index = idx;
        i_in_valid = 1'b1;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_address_item(cmd, hi, lo, idx);
        if ($urandom_range(0, 39) == 0) begin
            in_burst = !in_burst;
        end
        @(negedge i_clk);
    endtask

    task automatic classify_addr(input logic [63:0] hi, input logic [63:0] lo);
        drive_item(CMD_CLASSIFY, hi, lo, 6'($urandom_range(0, 63)));
    endtask

    task automatic read_counter(input logic [5:0] idx);
        drive_item(CMD_READ, rand64(), rand64(), idx);
    endtask

    // result side: random stall before each result
    initial begin
        int unsigned   hold;
        t_class_result got;
        i_out_stall = 1'b0;
        wait (i_rst_n);
        @(negedge i_clk);
        forever begin
            hold = out_burst ? 0 : $urandom_range(0, 10);
            if (hold != 0) begin
                i_out_stall = 1'b1;
                repeat (hold) @(negedge i_clk);
                i_out_stall = 1'b0;
            end
            do @(posedge i_clk); while (o_out_valid !== 1'b1);
            got.addr_type = o_addr_type;
            got.addr_subtype = o_addr_subtype;
            got.addr_scope = o_addr_scope;
            got.iid_type = o_iid_type;
            got.oui = o_oui;
            got.counter_value = o_counter_value;
            sb.check_class_result(got);
            if ($urandom_range(0, 39) == 0) begin
                out_burst = !out_burst;
            end
            @(negedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("status: fail");
                $finish;
            end
        end
    end

    initial begin
        logic [63:0] hi;
        logic [63:0] lo;
        sb = new();
        in_burst = 1'b0;
        out_burst = 1'b0;
        idle_cycles = 0;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_cmd = CMD_CLASSIFY;
        i_addr_high = '0;
        i_addr_low = '0;
        i_counter_index = '0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // one of each address kind and interface id class
        classify_addr(64'h0, 64'h0);
        classify_addr(64'h0, 64'h1);
        classify_addr(64'h0, 64'h0000ffff_01020304);
        classify_addr(64'h0, 64'h00000000_01020304);
        classify_addr(64'h0, 64'hffffffff_ffffffff);
        classify_addr(64'hfe80_0000_0000_0000, 64'h0211_22ff_fe33_4455);
        classify_addr(64'hfec0_0000_0000_0000, 64'h0000_5efe_c0a8_0001);
        classify_addr(64'hfd00_1234_0000_0000, 64'h0200_5efe_0a00_0001);
        classify_addr(64'h2002_c0a8_0101_0000, 64'h0000_0000_c0a8_0101);
        classify_addr(64'h2001_0000_4136_e378, 64'h8000_f227_bec5_ddec);
        classify_addr(64'h3ffe_831f_0000_0001, 64'h0000_0000_0000_0001);
        classify_addr(64'h2001_0db8_0000_0000, 64'h0000_0000_0000_0443);
        classify_addr(64'h2001_0db8_0000_0001, 64'h0000_0000_0050_0000);
        classify_addr(64'h2001_0db8_0000_0002, 64'h0000_0000_0000_0001);
        classify_addr(64'h2001_0db8_0000_0003, 64'h0192_0168_0001_0001);
        classify_addr(64'h2001_0db8_0000_0004, 64'h1234_0000_0000_5678);
        classify_addr(64'h2001_0db8_0000_0005, 64'h8f3a_c1d2_7e45_9b61);
        // multicast, flags 8 to 15 land in the unknown class
        classify_addr(64'hffff_ffff_ffff_ffff, 64'hffff_ffff_ffff_ffff);
        classify_addr(64'hff02_0000_0000_0000, 64'h1);
        classify_addr(64'hff3e_0000_0000_0000, 64'h0);
        classify_addr(64'hff75_0000_0000_0000, 64'h0);
        classify_addr(64'hff18_0000_0000_0000, 64'h0);
        // reads, including indexes past the last counter
        read_counter(6'd0);
        read_counter(6'd35);
        read_counter(6'd36);
        read_counter(6'd63);

        for (int n = 0; n < NUM_ITEMS; n++) begin
            if ($urandom_range(0, 7) == 0) begin
                read_counter(6'($urandom_range(0, 3) == 0 ? $urandom_range(0, 63)
                                                          : $urandom_range(0, 35)));
            end else begin
                hi = rand_prefix();
                lo = rand_iid();
                if (hi == '0) begin
                    case ($urandom_range(0, 4))
                        0:       lo = '0;
                        1:       lo = 64'h1;
                        2:       lo[63:32] = 32'h0000ffff;
                        3:       lo[63:32] = '0;
                        default: ;
                    endcase
                end
                classify_addr(hi, lo);
            end
        end
        i_in_valid = 1'b0;

        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end
endmodule
